// ----- rtl/best_fit_segment_allocator_macros.svh -----
// Assertion helpers for best_fit_segment_allocator.sv.
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, off during reset.
`define BFSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define BFSA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bfsa_pkg.sv -----
package bfsa_pkg;

  localparam int POOL_GRANULES = 65536;
  localparam int MAX_SEGMENTS  = 64;
  localparam int GRANULE_BYTES = 32;
  localparam int HEADER_BYTES  = 4;

  localparam int BYTES_W       = 22;
  localparam int IDX_W         = 16;
  localparam int LEN_W         = 17;
  localparam int SEG_AW        = 6;
  localparam int CNT_W         = 7;
  localparam int GRANULE_SHIFT = 5;
  localparam int NEED_W        = BYTES_W + 1 - GRANULE_SHIFT;
  localparam int SEG_W         = IDX_W + LEN_W;

  localparam logic [LEN_W-1:0] POOL_LEN = LEN_W'(POOL_GRANULES);
  localparam logic [CNT_W-1:0] SEG_FULL = CNT_W'(MAX_SEGMENTS);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_FWAIT, S_SCAN, S_SHIFT, S_COMMIT, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    CM_NONE, CM_NOFIT, CM_FULL, CM_NOTALLOC, CM_EXACT, CM_CUT, CM_EXTEND, CM_INSERT
  } commit_t;

  typedef enum logic [1:0] {
    SW_SCAN, SW_SHDN, SW_SHUP
  } sweep_t;

  typedef struct packed {
    logic    load;
    logic    scan_go;
    logic    shdn_go;
    logic    shup_go;
    logic    look;
    logic    flen_cap;
    commit_t commit;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_free;
    logic count_zero;
    logic full;
    logic found;
    logic hit_last;
    logic have_best;
    logic flen_zero;
    logic sweep_idle;
  } stat_t;

endpackage

// ----- rtl/best_fit_segment_allocator.sv -----
// Allocate scans the segment table; when an exact fit at i is removed, the entries after i
// shift down. Free scans it too, and shifts all entries up when a new segment goes in at the head.
// One request at a time; scan and shift read the segment table one entry per cycle.
// Reset (rst, synchronous): a clearing pass zeroes the block length store;
// no request is taken until it completes.
`include "best_fit_segment_allocator_macros.svh"

module best_fit_segment_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // request_bytes[21:0], block_index[37:22], zero pad
  input  logic        s_tuser,   // action: 0 allocate, 1 free
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // granted_index[15:0], granted_granules[32:16],
                                 // free_granules[49:33], zero pad
  output logic [1:0]  m_tuser    // status
);

  bfsa_pkg::cmd_t  cmd;
  bfsa_pkg::stat_t stat;

  logic [1:0]                 out_status;
  logic [bfsa_pkg::IDX_W-1:0] out_idx;
  logic [bfsa_pkg::LEN_W-1:0] out_gr;
  logic [bfsa_pkg::LEN_W-1:0] out_free;

  // Controller: sequence scan, shift and commit for one request at a time,
  // hold the result in the output register until taken.
  bfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath: segment table and block length store, the sweep engine that
  // walks the table one entry per cycle, and the result registers.
  bfsa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (s_tuser),
    .in_bytes   (s_tdata[21:0]),
    .in_blk     (s_tdata[37:22]),
    .out_status (out_status),
    .out_idx    (out_idx),
    .out_gr     (out_gr),
    .out_free   (out_free)
  );

  assign m_tuser = out_status;
  assign m_tdata = {6'b0, out_free, out_gr, out_idx};

  // no request is taken before the store is cleared
  `BFSA_ASSERT_IMP(a_ready_after_clear, clk, rst, s_tready, stat.clear_done, "request during clear")
  // table and store change only once the sweep has drained
  `BFSA_ASSERT_IMP(a_commit_idle, clk, rst, cmd.commit != bfsa_pkg::CM_NONE, stat.sweep_idle,
    "commit during sweep")
  // a granted or returned block is never empty
  `BFSA_ASSERT_IMP(a_ok_nonzero, clk, rst, m_tvalid && m_tuser == bfsa_pkg::ST_OK,
    m_tdata[32:16] != '0, "ok result with zero granules")
  // a commit is followed by the result stage
  `BFSA_ASSERT_NXT(a_commit_finish, clk, rst, cmd.commit != bfsa_pkg::CM_NONE,
    !s_tready && stat.sweep_idle, "commit not followed by finish")

endmodule

// ----- rtl/bfsa_ram.sv -----
module bfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bfsa_ctrl.sv -----
module bfsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic            m_tready,
  output logic            m_tvalid,
  output bfsa_pkg::cmd_t  cmd,
  input  bfsa_pkg::stat_t stat
);

  bfsa_pkg::state_t state, state_next;
  logic             m_tvalid_next;
  logic             out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bfsa_pkg::S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bfsa_pkg::S_CLEAR:  if (stat.clear_done) state_next = bfsa_pkg::S_IDLE;
      bfsa_pkg::S_IDLE:   if (s_tvalid) state_next = bfsa_pkg::S_START;
      bfsa_pkg::S_START: begin
        if (stat.is_free) state_next = bfsa_pkg::S_FWAIT;
        else if (stat.count_zero) state_next = bfsa_pkg::S_COMMIT;
        else state_next = bfsa_pkg::S_SCAN;
      end
      bfsa_pkg::S_FWAIT: begin
        state_next = stat.count_zero ? bfsa_pkg::S_COMMIT : bfsa_pkg::S_SCAN;
      end
      bfsa_pkg::S_SCAN: begin
        if (stat.sweep_idle) begin
          if ((!stat.is_free && stat.found && !stat.hit_last) ||
              (stat.is_free && !stat.flen_zero && !stat.found && !stat.full)) begin
            state_next = bfsa_pkg::S_SHIFT;
          end else begin
            state_next = bfsa_pkg::S_COMMIT;
          end
        end
      end
      bfsa_pkg::S_SHIFT:  if (stat.sweep_idle) state_next = bfsa_pkg::S_COMMIT;
      bfsa_pkg::S_COMMIT: state_next = bfsa_pkg::S_FINISH;
      bfsa_pkg::S_FINISH: if (out_free) state_next = bfsa_pkg::S_IDLE;
      default:            state_next = bfsa_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.commit    = bfsa_pkg::CM_NONE;
    s_tready      = 1'b0;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      bfsa_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      bfsa_pkg::S_START: begin
        cmd.look    = stat.is_free;
        cmd.scan_go = !stat.is_free && !stat.count_zero;
      end
      bfsa_pkg::S_FWAIT: begin
        cmd.flen_cap = 1'b1;
        cmd.scan_go  = !stat.count_zero;
      end
      bfsa_pkg::S_SCAN: begin
        if (stat.sweep_idle) begin
          cmd.shdn_go = !stat.is_free && stat.found && !stat.hit_last;
          cmd.shup_go = stat.is_free && !stat.flen_zero && !stat.found && !stat.full;
        end
      end
      bfsa_pkg::S_COMMIT: begin
        if (!stat.is_free) begin
          if (stat.found) cmd.commit = bfsa_pkg::CM_EXACT;
          else if (stat.have_best) cmd.commit = bfsa_pkg::CM_CUT;
          else cmd.commit = bfsa_pkg::CM_NOFIT;
        end else begin
          if (stat.flen_zero) cmd.commit = bfsa_pkg::CM_NOTALLOC;
          else if (stat.found) cmd.commit = bfsa_pkg::CM_EXTEND;
          else if (stat.full) cmd.commit = bfsa_pkg::CM_FULL;
          else cmd.commit = bfsa_pkg::CM_INSERT;
        end
      end
      bfsa_pkg::S_FINISH: begin
        if (out_free) begin
          cmd.res_load  = 1'b1;
          m_tvalid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/bfsa_dp.sv -----
module bfsa_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  bfsa_pkg::cmd_t                 cmd,
  output bfsa_pkg::stat_t                stat,
  input  logic                           in_action,
  input  logic [bfsa_pkg::BYTES_W-1:0]   in_bytes,
  input  logic [bfsa_pkg::IDX_W-1:0]     in_blk,
  output logic [1:0]                     out_status,
  output logic [bfsa_pkg::IDX_W-1:0]     out_idx,
  output logic [bfsa_pkg::LEN_W-1:0]     out_gr,
  output logic [bfsa_pkg::LEN_W-1:0]     out_free
);

  localparam int IW = bfsa_pkg::IDX_W;
  localparam int LW = bfsa_pkg::LEN_W;
  localparam int AW = bfsa_pkg::SEG_AW;
  localparam int CW = bfsa_pkg::CNT_W;
  localparam int NW = bfsa_pkg::NEED_W;
  localparam int SW = bfsa_pkg::SEG_W;

  // request registers
  logic          action;
  logic [NW-1:0] need;
  logic [IW-1:0] blk;
  logic [LW-1:0] flen;
  logic [bfsa_pkg::BYTES_W:0] need_sum;

  // table state
  logic [CW-1:0] count;
  logic [LW-1:0] free_total;

  // sweep engine
  logic             run, rvld;
  bfsa_pkg::sweep_t mode, rmode;
  logic [CW-1:0]    ptr;
  logic [CW-1:0]    last;
  logic [AW-1:0]    ridx;

  // scan results
  logic          found, have_best;
  logic [AW-1:0] hidx, bidx;
  logic [IW-1:0] hstart, bstart;
  logic [LW-1:0] hlen, blen;

  // clearing pass
  logic [IW-1:0] clr_addr;
  logic          clear_done;

  // staged result
  logic [1:0]    st_r;
  logic [IW-1:0] gidx_r;
  logic [LW-1:0] ggr_r;

  // memory ports
  logic          seg_we;
  logic [AW-1:0] seg_waddr;
  logic [SW-1:0] seg_wdata, seg_rdata;
  logic          sto_we;
  logic [IW-1:0] sto_waddr;
  logic [LW-1:0] sto_wdata, sto_rdata;

  logic [IW-1:0]   rs;
  logic [LW-1:0]   rl;
  logic            cmp_en, hit_now, better;
  logic [LW:0]     end_sum;
  logic [LW-1:0]   cut_len;
  logic [IW-1:0]   cut_blk;

  assign need_sum = {1'b0, in_bytes} +
    (bfsa_pkg::BYTES_W + 1)'(bfsa_pkg::HEADER_BYTES + bfsa_pkg::GRANULE_BYTES - 1);

  assign rs      = seg_rdata[IW-1:0];
  assign rl      = seg_rdata[SW-1:IW];
  assign end_sum = {2'b0, rs} + {1'b0, rl};
  assign cmp_en  = rvld && (rmode == bfsa_pkg::SW_SCAN) && !found;
  assign hit_now = cmp_en && (action ? (end_sum == {2'b0, blk}) : ({1'b0, rl} == need));
  assign better  = cmp_en && !action && ({1'b0, rl} > need) && (!have_best || rl < blen);
  assign last    = (mode == bfsa_pkg::SW_SHUP) ? '0 : count - 1'b1;
  assign cut_len = blen - need[LW-1:0];
  assign cut_blk = bstart + cut_len[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= in_action;
      need   <= need_sum[bfsa_pkg::BYTES_W:bfsa_pkg::GRANULE_SHIFT];
      blk    <= in_blk;
    end
    if (cmd.flen_cap) begin
      flen <= sto_rdata;
    end
    if (hit_now) begin
      hidx   <= ridx;
      hstart <= rs;
      hlen   <= rl;
    end
    if (better) begin
      bidx   <= ridx;
      bstart <= rs;
      blen   <= rl;
    end
    ridx  <= ptr[AW-1:0];
    rmode <= mode;
    if (cmd.scan_go) begin
      ptr  <= '0;
      mode <= bfsa_pkg::SW_SCAN;
    end else if (cmd.shdn_go) begin
      ptr  <= {1'b0, hidx} + 1'b1;
      mode <= bfsa_pkg::SW_SHDN;
    end else if (cmd.shup_go) begin
      ptr  <= count - 1'b1;
      mode <= bfsa_pkg::SW_SHUP;
    end else if (run && ptr != last) begin
      ptr <= (mode == bfsa_pkg::SW_SHUP) ? ptr - 1'b1 : ptr + 1'b1;
    end
    if (cmd.res_load) begin
      out_status <= st_r;
      out_idx    <= gidx_r;
      out_gr     <= ggr_r;
      out_free   <= free_total;
    end
    if (cmd.commit != bfsa_pkg::CM_NONE) begin
      gidx_r <= '0;
      ggr_r  <= '0;
      unique case (cmd.commit)
        bfsa_pkg::CM_NOFIT:    st_r <= bfsa_pkg::ST_NO_FIT;
        bfsa_pkg::CM_FULL:     st_r <= bfsa_pkg::ST_TABLE_FULL;
        bfsa_pkg::CM_NOTALLOC: st_r <= bfsa_pkg::ST_NOT_ALLOC;
        bfsa_pkg::CM_EXACT: begin
          st_r   <= bfsa_pkg::ST_OK;
          gidx_r <= hstart;
          ggr_r  <= need[LW-1:0];
        end
        bfsa_pkg::CM_CUT: begin
          st_r   <= bfsa_pkg::ST_OK;
          gidx_r <= cut_blk;
          ggr_r  <= need[LW-1:0];
        end
        default: begin
          st_r  <= bfsa_pkg::ST_OK;
          ggr_r <= flen;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= CW'(1);
      free_total <= bfsa_pkg::POOL_LEN;
      run        <= 1'b0;
      rvld       <= 1'b0;
      found      <= 1'b0;
      have_best  <= 1'b0;
      clr_addr   <= '0;
      clear_done <= 1'b0;
    end else begin
      rvld <= run;
      if (!clear_done) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) clear_done <= 1'b1;
      end
      if (cmd.load) begin
        found     <= 1'b0;
        have_best <= 1'b0;
      end
      if (hit_now) found <= 1'b1;
      if (better) have_best <= 1'b1;
      // start a sweep, stop it on a hit or after its last entry
      if (cmd.scan_go || cmd.shdn_go || cmd.shup_go) begin
        run <= 1'b1;
      end else if (hit_now || (run && ptr == last)) begin
        run <= 1'b0;
      end
      unique case (cmd.commit)
        bfsa_pkg::CM_EXACT: begin
          count      <= count - 1'b1;
          free_total <= free_total - need[LW-1:0];
        end
        bfsa_pkg::CM_CUT:    free_total <= free_total - need[LW-1:0];
        bfsa_pkg::CM_EXTEND: free_total <= free_total + flen;
        bfsa_pkg::CM_INSERT: begin
          count      <= count + 1'b1;
          free_total <= free_total + flen;
        end
        default: begin
        end
      endcase
    end
  end

  // segment table write port
  always_comb begin
    seg_we    = 1'b0;
    seg_waddr = '0;
    seg_wdata = {bfsa_pkg::POOL_LEN, IW'(0)};
    if (!clear_done) begin
      seg_we = 1'b1;
    end else if (rvld && rmode == bfsa_pkg::SW_SHDN) begin
      seg_we    = 1'b1;
      seg_waddr = ridx - 1'b1;
      seg_wdata = seg_rdata;
    end else if (rvld && rmode == bfsa_pkg::SW_SHUP) begin
      seg_we    = 1'b1;
      seg_waddr = ridx + 1'b1;
      seg_wdata = seg_rdata;
    end else begin
      case (cmd.commit)
        bfsa_pkg::CM_CUT: begin
          seg_we    = 1'b1;
          seg_waddr = bidx;
          seg_wdata = {cut_len, bstart};
        end
        bfsa_pkg::CM_EXTEND: begin
          seg_we    = 1'b1;
          seg_waddr = hidx;
          seg_wdata = {hlen + flen, hstart};
        end
        bfsa_pkg::CM_INSERT: begin
          seg_we    = 1'b1;
          seg_wdata = {flen, blk};
        end
        default: begin
        end
      endcase
    end
  end

  // block length store write port
  always_comb begin
    sto_we    = 1'b0;
    sto_waddr = blk;
    sto_wdata = '0;
    if (!clear_done) begin
      sto_we    = 1'b1;
      sto_waddr = clr_addr;
    end else begin
      case (cmd.commit)
        bfsa_pkg::CM_EXACT: begin
          sto_we    = 1'b1;
          sto_waddr = hstart;
          sto_wdata = need[LW-1:0];
        end
        bfsa_pkg::CM_CUT: begin
          sto_we    = 1'b1;
          sto_waddr = cut_blk;
          sto_wdata = need[LW-1:0];
        end
        bfsa_pkg::CM_EXTEND, bfsa_pkg::CM_INSERT: sto_we = 1'b1;
        default: begin
        end
      endcase
    end
  end

  bfsa_ram #(.WIDTH(SW), .DEPTH(bfsa_pkg::MAX_SEGMENTS)) u_seg (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .re    (run),
    .raddr (ptr[AW-1:0]),
    .rdata (seg_rdata)
  );

  bfsa_ram #(.WIDTH(LW), .DEPTH(bfsa_pkg::POOL_GRANULES)) u_store (
    .clk   (clk),
    .we    (sto_we),
    .waddr (sto_waddr),
    .wdata (sto_wdata),
    .re    (cmd.look),
    .raddr (blk),
    .rdata (sto_rdata)
  );

  always_comb begin
    stat.clear_done = clear_done;
    stat.is_free    = action;
    stat.count_zero = (count == '0);
    stat.full       = (count >= bfsa_pkg::SEG_FULL);
    stat.found      = found;
    stat.hit_last   = ({1'b0, hidx} == count - 1'b1);
    stat.have_best  = have_best;
    stat.flen_zero  = (flen == '0);
    stat.sweep_idle = !run && !rvld;
  end

endmodule
